/* rtl/core/mlrq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_pkg
// Shared constants, codes and types of the multilevel ready queue.
// ----------------------------------------------------------------------------
package mlrq_pkg;

    // Sizes of the cell chain and of the stored fields.
    localparam int CAPACITY   = 32;
    localparam int LEVELS     = 8;
    localparam int ID_WIDTH   = 8;
    localparam int LEVEL_W    = 3;
    localparam int PRESENCE_W = 2 ** LEVEL_W;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int LVLCNT_W   = 4;
    localparam int CFG_W      = 4;

    // Request operations.
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_TAKE    = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_MISS     = 2'd2,
        ST_BAD_PRIO = 2'd3
    } status_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_MULTILEVEL  = 1'b0,
        REG_LEVEL_COUNT = 1'b1
    } cfg_reg_t;

    // Contents of one cell.
    typedef struct packed {
        logic                valid;
        logic [LEVEL_W-1:0]  level;
        logic [ID_WIDTH-1:0] id;
    } cell_data_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                multilevel;
        logic                search_id;
        logic [ID_WIDTH-1:0] id;
        logic [LEVEL_W-1:0]  level;
        logic [LEVEL_W-1:0]  wr_level;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/mlrq_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq request and response channels
// Valid/ready channels that carry requests into and responses out of the queue.
// ----------------------------------------------------------------------------

// Request channel: one scheduler event.
interface mlrq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] process_id;
    logic [2:0] priority_req;

    modport source (output valid, output operation, output process_id,
                    output priority_req, input ready);
    modport sink   (input valid, input operation, input process_id,
                    input priority_req, output ready);
endinterface

// Response channel: one report per request.
interface mlrq_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] taken_id;
    logic [2:0] taken_priority;
    logic [3:0] top_level;
    logic [5:0] ready_count;
    logic       none_queued;

    modport source (output valid, output status, output taken_id,
                    output taken_priority, output top_level,
                    output ready_count, output none_queued, input ready);
    modport sink   (input valid, input status, input taken_id,
                    input taken_priority, input top_level,
                    input ready_count, input none_queued, output ready);
endinterface
`default_nettype wire

/* rtl/core/multilevel_ready_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_ready_queue
// Ready queue of process ids held in a chain of cells in arrival order; each
// level is served FIFO and the lowest non-empty level goes first.
// ----------------------------------------------------------------------------
// Flow: after a request is accepted, the match, shift and report states run in
// order (search, chain update, report); the report state waits while the previous response waits.
// A new request is accepted only once the previous one has been reported.
// A new request is taken while the previous response still waits in its register.
// Reset: the chain is empty, multilevel mode on, level count 8; no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_ready_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    mlrq_req_if.sink                           req,
    mlrq_rsp_if.source                         rsp,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [mlrq_pkg::CFG_W-1:0]    cfg_data
);
    import mlrq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_SHIFT,
        S_REPORT
    } state_t;

    state_t              state_reg;
    op_t                 op_reg;
    logic [ID_WIDTH-1:0] pid_reg;
    logic [LEVEL_W-1:0]  prio_reg;
    status_t             status_reg;
    logic [CAPACITY-1:0] first_reg;
    logic                do_shift_reg;
    logic                do_write_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ID_WIDTH-1:0] tid_reg;
    logic [LEVEL_W-1:0]  tprio_reg;
    logic                ml_reg;
    logic [LVLCNT_W-1:0] lvl_cnt_reg;

    logic                rsp_valid_reg;
    status_t             rsp_status_reg;
    logic [7:0]          rsp_tid_reg;
    logic [2:0]          rsp_tprio_reg;
    logic [3:0]          rsp_hp_reg;
    logic [5:0]          rsp_count_reg;
    logic                rsp_empty_reg;

    cell_data_t          cells [CAPACITY];
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] shift_vec;
    logic [CAPACITY-1:0] write_vec;
    cell_ctrl_t          ctrl;
    logic [PRESENCE_W-1:0] presence;
    logic [LEVEL_W-1:0]  best_level;
    logic [LVLCNT_W-1:0] eff_levels;
    logic [ID_WIDTH-1:0] sel_id;
    logic [LEVEL_W-1:0]  sel_level;

    // Lowest set bit of the level presence vector.
    function automatic logic [LEVEL_W-1:0] lowest_level(input logic [PRESENCE_W-1:0] p);
        logic [LEVEL_W-1:0] res;
        res = '0;
        for (int i = PRESENCE_W - 1; i >= 0; i--)
        begin
            if (p[i])
            begin
                res = LEVEL_W'(i);
            end
        end
        return res;
    endfunction

    // Level count in use, clamped to the number of levels built.
    assign eff_levels = (lvl_cnt_reg > LVLCNT_W'(LEVELS)) ? LVLCNT_W'(LEVELS) : lvl_cnt_reg;

    // Which stored levels are present anywhere in the chain.
    always_comb
    begin
        presence = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cells[i].valid)
            begin
                presence[cells[i].level] = 1'b1;
            end
        end
    end

    assign best_level = ml_reg ? lowest_level(presence) : '0;

    // Broadcast controls for the cells.
    always_comb
    begin
        ctrl.multilevel = ml_reg;
        ctrl.search_id  = (op_reg == OP_REMOVE);
        ctrl.id         = pid_reg;
        ctrl.level      = (op_reg == OP_REMOVE) ? prio_reg : best_level;
        ctrl.wr_level   = ml_reg ? prio_reg : '0;
    end

    // Cells at and behind the hit take their neighbor; the tail slot loads an enqueue.
    always_comb
    begin
        shift_vec = '0;
        write_vec = '0;
        if (state_reg == S_SHIFT)
        begin
            if (do_shift_reg)
            begin
                shift_vec = ~(first_reg - 1'b1);
            end
            for (int i = 0; i < CAPACITY; i++)
            begin
                write_vec[i] = do_write_reg && (count_reg == CNT_W'(i));
            end
        end
    end

    // The chain of cells.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        cell_data_t next_data;
        if (g == CAPACITY - 1)
        begin : g_last
            assign next_data = '0;
        end
        else
        begin : g_mid
            assign next_data = cells[g+1];
        end

        mlrq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .next_data (next_data),
            .shift     (shift_vec[g]),
            .write     (write_vec[g]),
            .data      (cells[g]),
            .match     (match_vec[g])
        );
    end

    // Contents of the cell that was hit, for take-next.
    always_comb
    begin
        sel_id    = '0;
        sel_level = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_reg[i])
            begin
                sel_id    = sel_id | cells[i].id;
                sel_level = sel_level | cells[i].level;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ml_reg      <= 1'b1;
            lvl_cnt_reg <= LVLCNT_W'(LEVELS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MULTILEVEL:  ml_reg      <= cfg_data[0];
                REG_LEVEL_COUNT: lvl_cnt_reg <= cfg_data[LVLCNT_W-1:0];
                default:         ml_reg      <= ml_reg;
            endcase
        end
    end

    // Sequencer: accept, search, update the chain, report.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_NOP;
            pid_reg        <= '0;
            prio_reg       <= '0;
            status_reg     <= ST_OK;
            first_reg      <= '0;
            do_shift_reg   <= 1'b0;
            do_write_reg   <= 1'b0;
            count_reg      <= '0;
            tid_reg        <= '0;
            tprio_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_tid_reg    <= '0;
            rsp_tprio_reg  <= '0;
            rsp_hp_reg     <= '0;
            rsp_count_reg  <= '0;
            rsp_empty_reg  <= 1'b1;
        end
        else
        begin
            // The response register empties when the consumer takes it, unless
            // the report state reloads it in the same cycle.
            if (rsp_valid_reg && rsp.ready && (state_reg != S_REPORT))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg    <= op_t'(req.operation);
                        pid_reg   <= req.process_id[ID_WIDTH-1:0];
                        prio_reg  <= req.priority_req[LEVEL_W-1:0];
                        state_reg <= S_MATCH;
                    end
                end

                S_MATCH:
                begin
                    // Keep only the oldest hit.
                    first_reg    <= match_vec & (~match_vec + 1'b1);
                    do_shift_reg <= 1'b0;
                    do_write_reg <= 1'b0;
                    unique case (op_reg)
                        OP_ENQUEUE:
                        begin
                            if (ml_reg && ({1'b0, prio_reg} >= eff_levels))
                            begin
                                status_reg <= ST_BAD_PRIO;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                status_reg   <= ST_OK;
                                do_write_reg <= 1'b1;
                            end
                        end
                        OP_REMOVE, OP_TAKE:
                        begin
                            status_reg   <= (|match_vec) ? ST_OK : ST_MISS;
                            do_shift_reg <= |match_vec;
                        end
                        OP_NOP:
                        begin
                            status_reg <= ST_OK;
                        end
                        default:
                        begin
                            status_reg <= ST_OK;
                        end
                    endcase
                    state_reg <= S_SHIFT;
                end

                S_SHIFT:
                begin
                    if (op_reg == OP_TAKE && do_shift_reg)
                    begin
                        tid_reg   <= sel_id;
                        tprio_reg <= sel_level;
                    end
                    else
                    begin
                        tid_reg   <= '0;
                        tprio_reg <= '0;
                    end
                    if (do_shift_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    else if (do_write_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    state_reg <= S_REPORT;
                end

                S_REPORT:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_status_reg <= status_reg;
                        rsp_tid_reg    <= 8'(tid_reg);
                        rsp_tprio_reg  <= 3'(tprio_reg);
                        rsp_hp_reg     <= (count_reg == '0) ? 4'(eff_levels)
                                                            : 4'(best_level);
                        rsp_count_reg  <= 6'(count_reg);
                        rsp_empty_reg  <= (count_reg == '0);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready            = (state_reg == S_IDLE);
    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_status_reg;
    assign rsp.taken_id         = rsp_tid_reg;
    assign rsp.taken_priority   = rsp_tprio_reg;
    assign rsp.top_level        = rsp_hp_reg;
    assign rsp.ready_count      = rsp_count_reg;
    assign rsp.none_queued      = rsp_empty_reg;

endmodule
`default_nettype wire

/* rtl/core/mlrq_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlrq_cell
// One queue slot: holds an id and its level, flags a search hit, and either
// takes its neighbor's contents (close a gap) or loads a new entry.
// ----------------------------------------------------------------------------
module mlrq_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mlrq_pkg::cell_ctrl_t ctrl,
    input  wire mlrq_pkg::cell_data_t next_data,
    input  wire logic                shift,
    input  wire logic                write,
    output      mlrq_pkg::cell_data_t data,
    output      logic                match
);
    import mlrq_pkg::*;

    logic                valid_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [ID_WIDTH-1:0] id_reg;
    logic [LEVEL_W-1:0]  key;

    // Ordering key: the stored level, or one shared level in single-queue mode.
    assign key = ctrl.multilevel ? level_reg : '0;

    // Search hit: a given id (and level) for remove, the best key for take-next.
    always_comb
    begin
        if (ctrl.search_id)
        begin
            match = valid_reg && (id_reg == ctrl.id)
                    && (!ctrl.multilevel || (level_reg == ctrl.level));
        end
        else
        begin
            match = valid_reg && (key == ctrl.level);
        end
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= next_data.valid;
        end
        else if (write)
        begin
            valid_reg <= 1'b1;
        end
    end

    // Payload of the slot.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            level_reg <= next_data.level;
            id_reg    <= next_data.id;
        end
        else if (write)
        begin
            level_reg <= ctrl.wr_level;
            id_reg    <= ctrl.id;
        end
    end

    assign data = '{valid: valid_reg, level: level_reg, id: id_reg};

endmodule
`default_nettype wire
